/* design/lgu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lgu_pkg;

  localparam int ADC_W     = 12;
  localparam int POINT_W   = 8;
  localparam int PHASE_W   = 3;
  localparam int WIN       = 6;
  localparam int OUT_SHIFT = 5;
  localparam int OUT_MAX   = 255;

  // node denominators over s^5, oldest sample first
  localparam longint DEN_FACTOR [WIN] = '{-120, 24, -12, 12, -24, 120};

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  function automatic longint node_num(input int k, input int j, input int s);
    longint acc;
    acc = 1;
    for (int m = 0; m < WIN; m++) begin
      if (m != k) begin
        acc = acc * (longint'(j) - longint'(m - 2) * longint'(s));
      end
    end
    return acc;
  endfunction

  function automatic longint node_den(input int k, input int s);
    longint s5;
    s5 = longint'(s) * s * s * s * s;
    return s5 * DEN_FACTOR[k];
  endfunction

endpackage

`default_nettype wire

/* design/lgu_sample_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgu_sample_if;
  import lgu_pkg::*;

  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

/* design/lgu_point_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lgu_point_if;
  import lgu_pkg::*;

  logic               valid;
  logic               ready;
  logic [POINT_W-1:0] interp_point;
  logic [PHASE_W-1:0] phase;
  logic               run_last;

  modport source (output valid, output interp_point, output phase, output run_last,
                  input ready);
  modport sink (input valid, input interp_point, input phase, input run_last,
                output ready);
endinterface

`default_nettype wire

/* design/lgu_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgu_fifo #(
  parameter int W = 72
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire  [W-1:0]          push_data,
  input  wire                   pop,
  output logic [W-1:0]          pop_data,
  output lgu_pkg::q_stat_t      q_stat
);
  import lgu_pkg::*;

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data         = mem[rd_ptr];
  assign q_stat.not_empty = (count != 2'd0);
  assign q_stat.full      = (count == 2'd2);

endmodule

`default_nettype wire

/* design/lgu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgu_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire                                        clk,
  input  wire                                        rst,
  lgu_sample_if.sink                                 samples,
  input  wire  lgu_pkg::q_stat_t                     q_stat,
  output logic                                       push,
  output logic [lgu_pkg::WIN-1:0][SAMPLE_BITS-1:0]   push_win
);
  import lgu_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int RAW_W = (SB > ADC_W) ? SB : ADC_W;

  logic [WIN-1:0][SB-1:0] win;
  logic [WIN-1:0][SB-1:0] win_next;
  logic [2:0]             fill_count;
  logic [RAW_W-1:0]       raw;
  logic                   take;

  assign samples.ready = !q_stat.full;
  assign take          = samples.valid && samples.ready;
  assign raw           = RAW_W'(samples.adc_sample);

  always_comb begin
    for (int k = 0; k < WIN - 1; k++) begin
      win_next[k] = win[k+1];
    end
    win_next[WIN-1] = raw[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (take) win <= win_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= 3'd0;
    end else if (take && fill_count != 3'(WIN)) begin
      fill_count <= fill_count + 3'd1;
    end
  end

  // window is complete once this transfer lands
  assign push     = take && (fill_count >= 3'(WIN - 1));
  assign push_win = win_next;

endmodule

`default_nettype wire

/* design/lgu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lgu_back #(
  parameter int UPSAMPLE    = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire  lgu_pkg::q_stat_t                     q_stat,
  input  wire  [lgu_pkg::WIN-1:0][SAMPLE_BITS-1:0]   pop_win,
  output logic                                       pop,
  lgu_point_if.source                                points
);
  import lgu_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int JW = $clog2(UPSAMPLE);
  localparam int P  = SB + 1;
  localparam int FW = P + 2;
  localparam int NW = 5 * $clog2(4 * UPSAMPLE);
  localparam int DW = 5 * $clog2(UPSAMPLE) + 7;
  localparam int QW = SB + 3;
  localparam int TW = QW + 1;
  localparam int SW = TW + 3;
  localparam int MW = SB + FW;
  localparam int PW = SB + NW;
  localparam int KW = QW + DW;
  localparam int CW = (KW > PW) ? KW : PW;
  localparam logic [JW-1:0] LAST_J = JW'(UPSAMPLE - 1);

  // weight tables
  logic [FW-1:0] f_tab   [WIN][UPSAMPLE];
  logic [NW-1:0] n_tab   [WIN][UPSAMPLE];
  logic          neg_tab [WIN][UPSAMPLE];
  logic [DW-1:0] d_tab   [WIN];

  for (genvar k = 0; k < WIN; k++) begin : g_lane
    localparam longint DV = node_den(k, UPSAMPLE);
    localparam longint DA = (DV < 0) ? -DV : DV;
    assign d_tab[k] = DW'(DA);
    for (genvar jj = 0; jj < UPSAMPLE; jj++) begin : g_ph
      localparam longint NV = node_num(k, jj, UPSAMPLE);
      localparam longint NA = (NV < 0) ? -NV : NV;
      localparam longint FV = (NA << P) / DA;
      assign f_tab[k][jj]   = FW'(FV);
      assign n_tab[k][jj]   = NW'(NA);
      assign neg_tab[k][jj] = ((NV < 0) != (DV < 0));
    end
  end

  // phase sequencer
  logic                   busy;
  logic [JW-1:0]          j;
  logic [WIN-1:0][SB-1:0] cur;
  logic                   advance;
  logic                   issue;

  logic v1, v2, v3, v4;

  assign advance = !v4 || points.ready;
  assign issue   = busy && advance;
  assign pop     = q_stat.not_empty && (!busy || (issue && j == LAST_J));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      j    <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      j    <= '0;
    end else if (issue) begin
      if (j == LAST_J) begin
        busy <= 1'b0;
      end else begin
        j <= j + JW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_win;
  end

  // term pipeline
  logic [SB-1:0]        y1    [WIN];
  logic [FW-1:0]        f1    [WIN];
  logic [NW-1:0]        n1    [WIN];
  logic                 neg1  [WIN];
  logic [QW-1:0]        est2  [WIN];
  logic [PW-1:0]        prod2 [WIN];
  logic                 neg2  [WIN];
  logic signed [TW-1:0] term3 [WIN];

  logic [JW-1:0] j1, j2, j3;
  logic          last1, last2, last3;

  logic [MW-1:0]        est_m   [WIN];
  logic [QW-1:0]        est_inc [WIN];
  logic [KW-1:0]        chk     [WIN];
  logic [QW-1:0]        q       [WIN];
  logic signed [TW-1:0] mag     [WIN];
  logic signed [SW-1:0] acc;
  logic [SW-1:0]        shifted;

  logic [POINT_W-1:0] pt4;
  logic [PHASE_W-1:0] ph4;
  logic               last4;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      est_m[k]   = MW'(y1[k]) * MW'(f1[k]);
      est_inc[k] = est2[k] + QW'(1);
      chk[k]     = KW'(est_inc[k]) * KW'(d_tab[k]);
      q[k]       = (CW'(chk[k]) <= CW'(prod2[k])) ? est_inc[k] : est2[k];
      mag[k]     = TW'(q[k]);
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < WIN; k++) begin
      acc = acc + SW'(term3[k]);
    end
    shifted = SW'(acc >>> OUT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < WIN; k++) begin
        y1[k]    <= cur[k];
        f1[k]    <= f_tab[k][j];
        n1[k]    <= n_tab[k][j];
        neg1[k]  <= neg_tab[k][j];
        est2[k]  <= QW'(est_m[k] >> P);
        prod2[k] <= PW'(y1[k]) * PW'(n1[k]);
        neg2[k]  <= neg1[k];
        term3[k] <= neg2[k] ? -mag[k] : mag[k];
      end
      j1    <= j;
      last1 <= (j == LAST_J);
      j2    <= j1;
      last2 <= last1;
      j3    <= j2;
      last3 <= last2;
      if (acc < 0) begin
        pt4 <= '0;
      end else if (shifted > SW'(OUT_MAX)) begin
        pt4 <= POINT_W'(OUT_MAX);
      end else begin
        pt4 <= POINT_W'(shifted);
      end
      ph4   <= PHASE_W'(j3);
      last4 <= last3;
    end
  end

  assign points.valid        = v4;
  assign points.interp_point = pt4;
  assign points.phase        = ph4;
  assign points.run_last     = last4;

endmodule

`default_nettype wire

/* design/lagrange_six_point_upsampler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Six-point Lagrange upsampler.
// samples: one converter sample per transfer (valid/ready); only the low
//   SAMPLE_BITS bits are used.
// points: UPSAMPLE transfers per sample once six samples are held, phases
//   0 .. UPSAMPLE-1 in order, run_last set on the final phase.
// The first five samples after reset only fill the window and give no points.
// The first point of a sample passes the window queue, the held window and the
//   evaluation pipeline; the others follow one per cycle while points are taken.
// Throughput: one point per cycle while the receiver is ready; the phase
//   sequencer holds a window for all UPSAMPLE phases and pops the next one as
//   it issues the last phase. Samples that only fill the window go at one per cycle.
// A two-window queue sits between sample intake and evaluation, so samples
//   are still taken while points wait.
// When the receiver stalls the whole evaluation pipeline holds its contents,
//   the queue fills and samples.ready drops when it is full.
// Reset (rst, synchronous) empties the window count, the queue and the
//   pipeline; no point is pending afterwards.
module lagrange_six_point_upsampler #(
  parameter int UPSAMPLE    = 5,
  parameter int SAMPLE_BITS = 12
) (
  input  wire          clk,
  input  wire          rst,
  lgu_sample_if.sink   samples,
  lgu_point_if.source  points
);
  import lgu_pkg::*;

  localparam int QDW = WIN * SAMPLE_BITS;

  q_stat_t                         q_stat;
  logic                            q_push;
  logic                            q_pop;
  logic [WIN-1:0][SAMPLE_BITS-1:0] push_win;
  logic [WIN-1:0][SAMPLE_BITS-1:0] pop_win;
  logic [QDW-1:0]                  pop_data;

  lgu_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_win (push_win)
  );

  lgu_fifo #(
    .W(QDW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (QDW'(push_win)),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  assign pop_win = pop_data;

  lgu_back #(
    .UPSAMPLE    (UPSAMPLE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .pop_win (pop_win),
    .pop     (q_pop),
    .points  (points)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full && !q_pop))
    else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && !q_stat.not_empty))
    else $error("window queue underflow");

  a_last_phase: assert property (@(posedge clk) disable iff (rst)
    points.valid |-> (points.run_last == (points.phase == PHASE_W'(UPSAMPLE - 1))))
    else $error("run_last does not match final phase");

  a_phase_run: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.ready && !points.run_last) |=>
      (points.valid && points.phase == PHASE_W'($past(points.phase) + 3'd1)))
    else $error("phases of one sample not back to back");
`endif

endmodule

`default_nettype wire
